[hw/rtl/ukst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unordered key set table package
// Sizes, field layouts and request and status codes shared by the table
// and its testbench.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int CAPACITY  = 128;
  localparam int KEY_WIDTH = 32;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int ENTRY_W  = 8;

  localparam int IN_TDATA_W  = ((MODE_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STATUS_W + POS_W + ENTRY_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/ukst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ukst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/unordered_key_set_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// The table takes one item at a time; full or empty rejections skip the scan. The next
// item is accepted the cycle after the result is registered, and the result register can
// stall while the result side holds out_tready low.
// Throughput is set by the single key memory port pair, scanned one entry per cycle.
// Reset clears the entry count and all handshake state; the key memory is not cleared.
// ----------------------------------------------------------------------------
// Unordered key set table
// Linear-search set of distinct keys kept densely in arrival order, with
// search, insert and delete-with-compaction under a small sequencer.
// ----------------------------------------------------------------------------
module unordered_key_set_table
  import ukst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // mode [1:0], key [33:2]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // status [2:0], position [9:3],
                                                  // entry_count [17:10]
);

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]    res_pos_r, res_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [ENTRY_W-1:0]   out_count_r, out_count_nxt;

  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [KEY_WIDTH-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [KEY_WIDTH-1:0] ram_rd_data;
  logic                 hit;

  ukst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (issue_r[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign hit = pend_r && (ram_rd_data == key_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[ADDR_W-1:0];
    ram_wr_data    = key_r;
    ram_rd_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt       = in_tdata[MODE_W-1:0];
          key_nxt        = in_tdata[MODE_W +: KEY_WIDTH];
          issue_nxt      = '0;
          pend_nxt       = 1'b0;
          res_pos_nxt    = '0;
          res_status_nxt = ST_OK;
          if (in_tdata[MODE_W-1:0] == MODE_INSERT &&
              count_r == COUNT_W'(CAPACITY)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_FINISH;
          end else if (in_tdata[MODE_W-1:0] == MODE_DELETE && count_r == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (mode_r == MODE_INSERT) begin
            res_status_nxt = ST_DUP;
            state_nxt      = S_FINISH;
          end else if (mode_r == MODE_DELETE) begin
            res_pos_nxt = pend_idx_r;
            count_nxt   = count_r - 1'b1;
            issue_nxt   = COUNT_W'(pend_idx_r) + 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = S_SHIFT;
          end else begin
            res_pos_nxt = pend_idx_r;
            state_nxt   = S_FINISH;
          end
        end else if (issue_r < count_r) begin
          ram_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[ADDR_W-1:0];
          issue_nxt    = issue_r + 1'b1;
        end else begin
          if (mode_r == MODE_INSERT) begin
            ram_wr_en   = 1'b1;
            res_pos_nxt = count_r[ADDR_W-1:0];
            count_nxt   = count_r + 1'b1;
          end else begin
            res_status_nxt = ST_MISSING;
          end
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pend_idx_r - 1'b1;
          ram_wr_data = ram_rd_data;
        end
        if (issue_r <= count_r) begin
          ram_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[ADDR_W-1:0];
          issue_nxt    = issue_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = POS_W'(res_pos_r);
          out_count_nxt  = ENTRY_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_count_r, out_pos_r, out_status_r};

endmodule
`default_nettype wire

[bench/unordered_key_set_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unordered key set table testbench
// Drives search, insert, delete and spare requests on the input stream, with
// bursty traffic on the sender side and a changing stall pattern on the result
// side. A scoreboard keeps its own copy of the key table, predicts the status,
// position and entry count of every reply and compares them in order.
// ----------------------------------------------------------------------------
module unordered_key_set_table_tb;
  import ukst_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int ITEM_TARGET = 400;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [ENTRY_W-1:0]  entry_count;
  } reply_t;

  class key_table_model;
    logic [KEY_W-1:0] keys [CAPACITY];
    int unsigned      fill;
    reply_t           pending_replies [$];
    int unsigned      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k);
      reply_t r;
      int     slot;
      r.status   = ST_OK;
      r.position = '0;
      case (mode)
        MODE_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (find_slot(k) >= 0) begin
            r.status = ST_DUP;
          end else begin
            r.position = POS_W'(fill);
            keys[fill] = k;
            fill++;
          end
        end
        MODE_DELETE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            slot = find_slot(k);
            if (slot < 0) begin
              r.status = ST_MISSING;
            end else begin
              r.position = POS_W'(slot);
              fill--;
              for (int i = slot; i < fill; i++) keys[i] = keys[i + 1];
            end
          end
        end
        default: begin
          slot = find_slot(k);
          if (slot < 0) r.status = ST_MISSING;
          else r.position = POS_W'(slot);
        end
      endcase
      r.entry_count = ENTRY_W'(fill);
      pending_replies.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] data);
      reply_t want;
      reply_t got;
      got.status      = data[STATUS_W-1:0];
      got.position    = data[STATUS_W +: POS_W];
      got.entry_count = data[STATUS_W + POS_W +: ENTRY_W];
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected reply, expected none, actual %h", $time, data);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.position !== want.position) report("position", want.position, got.position);
      if (got.entry_count !== want.entry_count)
        report("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  key_table_model model = new();

  int          items_sent = 0;
  int          burst_left = 0;
  logic [31:0] rx_cycle   = '0;
  int          rx_style   = 0;

  unordered_key_set_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_reply(out_tdata);
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 97 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_cycle % 5 == 0);
      default: out_tready <= (rx_cycle[3:0] == 4'd9);
    endcase
  end

  task automatic pace_sender();
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(60, 120);
      else burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k);
    pace_sender();
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - MODE_W - KEY_W){1'b0}}, k, mode};
    do @(posedge clk); while (!in_tready);
    model.note_request(mode, k);
    items_sent++;
  endtask

  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending_replies.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] present_key();
    return model.keys[$urandom_range(0, model.fill - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && model.fill > 0) return present_key();
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 32'h0000_0001;
        default: return 32'h8000_0000;
      endcase
    end
    if (r < 70) return 32'h1000_0000 + $urandom_range(0, 15);
    return $urandom();
  endfunction

  task automatic fill_phase();
    int r;
    while (model.fill < CAPACITY) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_item(MODE_INSERT, $urandom());
      else if (r < 80) send_item(MODE_INSERT, pick_key());
      else if (r < 88) send_item(MODE_SEARCH, pick_key());
      else if (r < 94) send_item(MODE_SPARE, pick_key());
      else send_item(MODE_DELETE, pick_key());
    end
    repeat (4) send_item(MODE_INSERT, present_key());
    repeat (4) send_item(MODE_INSERT, $urandom());
    send_item(MODE_SEARCH, model.keys[CAPACITY - 1]);
    repeat (4) send_item(MODE_SEARCH, pick_key());
  endtask

  task automatic drain_phase();
    int r;
    while (model.fill > 0) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_item(MODE_DELETE, present_key());
      else if (r < 75) send_item(MODE_DELETE, pick_key());
      else if (r < 85) send_item(MODE_SEARCH, pick_key());
      else if (r < 90) send_item(MODE_INSERT, pick_key());
      else send_item(MODE_SPARE, pick_key());
    end
    repeat (3) send_item(MODE_DELETE, pick_key());
    send_item(MODE_SEARCH, pick_key());
  endtask

  task automatic mixed_phase(int count);
    repeat (count) send_item(MODE_W'($urandom_range(0, 3)), pick_key());
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(MODE_SEARCH, '0);
    send_item(MODE_DELETE, '0);
    send_item(MODE_SPARE, '0);
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, '1);
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, 32'hA5A5_5A5A);
    send_item(MODE_INSERT, 32'h5A5A_A5A5);
    send_item(MODE_SEARCH, '1);
    send_item(MODE_SPARE, 32'h5A5A_A5A5);
    send_item(MODE_SEARCH, 32'h1234_5678);
    send_item(MODE_DELETE, 32'h1234_5678);
    send_item(MODE_DELETE, '1);
    send_item(MODE_SEARCH, 32'hA5A5_5A5A);
    send_item(MODE_SEARCH, 32'h5A5A_A5A5);
    send_item(MODE_DELETE, 32'h5A5A_A5A5);
    send_item(MODE_DELETE, '0);
    send_item(MODE_DELETE, 32'hA5A5_5A5A);
    send_item(MODE_DELETE, 32'hA5A5_5A5A);
    send_item(MODE_SEARCH, 32'hA5A5_5A5A);
    wait_for_replies();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 3)
        0: fill_phase();
        1: mixed_phase(60);
        default: drain_phase();
      endcase
      phase++;
      wait_for_replies();
    end

    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (model.errors == 0 && model.pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
